/* design/aes_pkg.sv */
`default_nettype none
package aes_pkg;

  localparam int unsigned RoundCount = 10;
  localparam int unsigned RndW       = 4;
  localparam int unsigned AddrW      = 6;

  // Register byte addresses (8-byte spacing)
  localparam logic [AddrW-1:0] AddrKeyHigh = 6'd0;
  localparam logic [AddrW-1:0] AddrKeyLow  = 6'd8;
  localparam logic [AddrW-1:0] AddrIvHigh  = 6'd16;
  localparam logic [AddrW-1:0] AddrIvLow   = 6'd24;
  localparam logic [AddrW-1:0] AddrMode    = 6'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic            exp_init;
    logic            exp_step;
    logic            load;
    logic            round;
    logic            last;
    logic            finish;
    logic [RndW-1:0] rnd;
  } dp_cmd_t;

  typedef logic [7:0] byte_t;

  function automatic byte_t sbox(input byte_t v);
    byte_t t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[v];
  endfunction

  function automatic byte_t sbox_inv(input byte_t v);
    byte_t t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[v];
  endfunction

  function automatic byte_t rcon(input logic [RndW-1:0] k);
    unique case (k)
      4'd1:    return 8'h01;
      4'd2:    return 8'h02;
      4'd3:    return 8'h04;
      4'd4:    return 8'h08;
      4'd5:    return 8'h10;
      4'd6:    return 8'h20;
      4'd7:    return 8'h40;
      4'd8:    return 8'h80;
      4'd9:    return 8'h1b;
      4'd10:   return 8'h36;
      default: return 8'h00;
    endcase
  endfunction

  function automatic byte_t xt(input byte_t v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    byte_t a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
            xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  // inverse mix = forward mix after a pre-multiply step
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    byte_t a0, a1, a2, a3, u, v;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    u  = xt(xt(a0 ^ a2));
    v  = xt(xt(a1 ^ a3));
    return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

  // byte i at bits 127-8i; byte i = row i%4, col i/4
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8*(4*c + r) -: 8] = sbox(s[127 - 8*(4*((c + r) & 3) + r) -: 8]);
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8*(4*((c + r) & 3) + r) -: 8] = sbox_inv(s[127 - 8*(4*c + r) -: 8]);
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_all(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      o[127 - 32*c -: 32] = inv ? inv_mix_col(s[127 - 32*c -: 32])
                                : mix_col(s[127 - 32*c -: 32]);
    end
    return o;
  endfunction

endpackage
`default_nettype wire

/* design/aes_ctrl.sv */
`default_nettype none
module aes_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire logic            keys_ready,
  input  wire logic            decrypt,
  output aes_pkg::dp_cmd_t     cmd
);

  aes_pkg::state_t          state_r, state_nxt;
  logic [aes_pkg::RndW-1:0] cnt_r, cnt_nxt;
  logic                     dec_r, dec_nxt;

  // state and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aes_pkg::ST_IDLE;
      cnt_r   <= '0;
      dec_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dec_r   <= dec_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dec_nxt   = dec_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      aes_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (!keys_ready) begin
            cmd.exp_init = 1'b1;
            cnt_nxt      = 4'd1;
            state_nxt    = aes_pkg::ST_EXPAND;
          end else begin
            state_nxt = aes_pkg::ST_LOAD;
          end
        end
      end
      aes_pkg::ST_EXPAND: begin
        cmd.exp_step = 1'b1;
        cmd.rnd      = cnt_r;
        cnt_nxt      = cnt_r + 4'd1;
        if (cnt_r == aes_pkg::RndW'(aes_pkg::RoundCount)) begin
          state_nxt = aes_pkg::ST_LOAD;
        end
      end
      aes_pkg::ST_LOAD: begin
        // request taken here; first key add
        in_stall  = 1'b0;
        cmd.load  = 1'b1;
        cmd.rnd   = decrypt ? aes_pkg::RndW'(aes_pkg::RoundCount) : '0;
        dec_nxt   = decrypt;
        cnt_nxt   = 4'd1;
        state_nxt = aes_pkg::ST_ROUND;
      end
      aes_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        cmd.rnd   = dec_r ? aes_pkg::RndW'(aes_pkg::RoundCount) - cnt_r : cnt_r;
        cmd.last  = (cnt_r == aes_pkg::RndW'(aes_pkg::RoundCount));
        cnt_nxt   = cnt_r + 4'd1;
        if (cmd.last) begin
          cmd.finish = 1'b1;
          state_nxt  = aes_pkg::ST_DONE;
        end
      end
      aes_pkg::ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = aes_pkg::ST_IDLE;
        end
      end
      default: state_nxt = aes_pkg::ST_IDLE;
    endcase
  end

  a_load_has_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == aes_pkg::ST_LOAD |-> in_valid)
    else $error("load without input");
  a_round_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == aes_pkg::ST_DONE)
    else $error("finish did not reach done");
  a_one_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |=> in_stall)
    else $error("two accepts in a row");

endmodule
`default_nettype wire

/* design/aes_dp.sv */
`default_nettype none
module aes_dp (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire aes_pkg::dp_cmd_t cmd,
  input  wire logic             decrypt,
  input  wire logic             cfg_key_we,
  input  wire logic [127:0]     key,
  input  wire logic [127:0]     iv,
  input  wire logic [63:0]      in_block_high,
  input  wire logic [63:0]      in_block_low,
  input  wire logic             in_restart_chain,
  output logic                  keys_ready,
  output logic [127:0]          result
);

  logic [127:0] rk_mem [aes_pkg::RoundCount+1];
  logic [127:0] w_r, w_nxt;
  logic         ready_r;
  logic [127:0] st_r, st_nxt;
  logic [127:0] chain_r, chain_nxt;
  logic [127:0] res_r;
  logic         dec_r;
  logic [127:0] rk;
  logic [31:0]  t;
  logic [127:0] in_hold_r;

  // key schedule step
  always_comb begin
    t = {aes_pkg::sbox(w_r[23:16]) ^ aes_pkg::rcon(cmd.rnd), aes_pkg::sbox(w_r[15:8]),
         aes_pkg::sbox(w_r[7:0]), aes_pkg::sbox(w_r[31:24])};
    w_nxt[127:96] = w_r[127:96] ^ t;
    w_nxt[95:64]  = w_r[95:64] ^ w_nxt[127:96];
    w_nxt[63:32]  = w_r[63:32] ^ w_nxt[95:64];
    w_nxt[31:0]   = w_r[31:0] ^ w_nxt[63:32];
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_init) begin
      w_r       <= key;
      rk_mem[0] <= key;
    end else if (cmd.exp_step) begin
      w_r                <= w_nxt;
      rk_mem[cmd.rnd]    <= w_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
    end else if (cfg_key_we) begin
      ready_r <= 1'b0;
    end else if (cmd.exp_step && cmd.rnd == aes_pkg::RndW'(aes_pkg::RoundCount)) begin
      ready_r <= 1'b1;
    end
  end

  assign rk = rk_mem[cmd.rnd];

  // round unit
  always_comb begin
    logic [127:0] cv, x;
    cv        = in_restart_chain ? iv : chain_r;
    st_nxt    = st_r;
    chain_nxt = chain_r;
    x         = '0;
    if (cmd.load) begin
      st_nxt = decrypt ? ({in_block_high, in_block_low} ^ rk)
                       : ({in_block_high, in_block_low} ^ cv ^ rk);
      chain_nxt = cv;
    end else if (cmd.round) begin
      if (dec_r) begin
        x      = aes_pkg::inv_shift_sub(st_r) ^ rk;
        st_nxt = cmd.last ? x : aes_pkg::mix_all(x, 1'b1);
      end else begin
        x      = aes_pkg::sub_shift(st_r);
        st_nxt = (cmd.last ? x : aes_pkg::mix_all(x, 1'b0)) ^ rk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      chain_r <= '0;
    end else begin
      st_r    <= st_nxt;
      chain_r <= chain_nxt;
      if (cmd.finish) begin
        chain_r <= dec_r ? {in_hold_r} : st_nxt;
      end
    end
  end

  // ciphertext kept for decrypt chaining
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_hold_r <= {in_block_high, in_block_low};
      dec_r     <= decrypt;
    end
    if (cmd.finish) begin
      res_r <= dec_r ? (st_nxt ^ chain_r) : st_nxt;
    end
  end

  assign keys_ready = ready_r;
  assign result     = res_r;

  a_key_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_key_we |=> !keys_ready)
    else $error("key write left keys ready");
  a_no_load_unready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> keys_ready)
    else $error("load before key expansion");
  a_chain_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && !dec_r |=> chain_r == res_r)
    else $error("encrypt chain mismatch");

endmodule
`default_nettype wire

/* design/aes128_cbc_cipher_core.sv */
// AES-128 CBC cipher core.
// Input channel: in_valid/in_stall with in_block_high, in_block_low and
// in_restart_chain; one request is one 128-bit block. Output channel:
// out_valid/out_stall with out_out_high and out_out_low.
// Configuration: APB-style port, 64-bit data, registers at 8-byte steps:
// key_high, key_low, iv_high, iv_low, decrypt_mode. Write only while idle.
// A request is taken after an idle check, in a load step that also does
// the first key add; ten rounds follow, one per cycle through a single
// round unit, and the result is shown the cycle after the last round. No
// new request is taken until the result has left without a stall.
// After a key write the next request first runs the key schedule, one
// round key a cycle.
// Reset clears the key-ready flag, the chaining value, the controller and
// the configuration registers; the round keys are rebuilt before first use.
// While out_stall is high the result holds and no new request is taken.
`default_nettype none
module aes128_cbc_cipher_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [63:0]               in_block_high,
  input  wire logic [63:0]               in_block_low,
  input  wire logic                      in_restart_chain,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [63:0]                    out_out_high,
  output logic [63:0]                    out_out_low,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [aes_pkg::AddrW-1:0] paddr,
  input  wire logic [63:0]               pwdata,
  output logic [63:0]                    prdata,
  output logic                           pready
);

  logic [63:0]               key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
  logic                      mode_r;
  logic                      wr, key_we, keys_ready;
  logic [aes_pkg::AddrW-1:0] addr;
  logic [127:0]              result;
  aes_pkg::dp_cmd_t          cmd;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign addr   = paddr;
  assign key_we = wr && (addr == aes_pkg::AddrKeyHigh || addr == aes_pkg::AddrKeyLow);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      iv_hi_r  <= '0;
      iv_lo_r  <= '0;
      mode_r   <= 1'b0;
    end else if (wr) begin
      unique case (addr)
        aes_pkg::AddrKeyHigh: key_hi_r <= pwdata;
        aes_pkg::AddrKeyLow:  key_lo_r <= pwdata;
        aes_pkg::AddrIvHigh:  iv_hi_r  <= pwdata;
        aes_pkg::AddrIvLow:   iv_lo_r  <= pwdata;
        aes_pkg::AddrMode:    mode_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (addr)
      aes_pkg::AddrKeyHigh: prdata = key_hi_r;
      aes_pkg::AddrKeyLow:  prdata = key_lo_r;
      aes_pkg::AddrIvHigh:  prdata = iv_hi_r;
      aes_pkg::AddrIvLow:   prdata = iv_lo_r;
      aes_pkg::AddrMode:    prdata = {63'd0, mode_r};
      default:              prdata = '0;
    endcase
  end

  aes_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .keys_ready (keys_ready),
    .decrypt    (mode_r),
    .cmd        (cmd)
  );

  aes_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .decrypt          (mode_r),
    .cfg_key_we       (key_we),
    .key              ({key_hi_r, key_lo_r}),
    .iv               ({iv_hi_r, iv_lo_r}),
    .in_block_high    (in_block_high),
    .in_block_low     (in_block_low),
    .in_restart_chain (in_restart_chain),
    .keys_ready       (keys_ready),
    .result           (result)
  );

  assign out_out_high = result[127:64];
  assign out_out_low  = result[63:0];

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(result))
    else $error("result dropped under stall");
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("accept while result pending");
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule
`default_nettype wire
